/* sv/bma_pkg.sv */
// Shared types, widths and register indexes for the block mosaic averager.
package bma_pkg;

    localparam int MAX_FRAME_WIDTH  = 2048;
    localparam int MAX_FRAME_HEIGHT = 2048;
    localparam int COL_W            = 11;
    localparam int CFG_W            = 12;
    localparam int SHIFT_W          = 4;
    localparam int AMT_W            = 5;
    localparam int CH_W             = 8;
    localparam int SUM_W            = 28;
    localparam int CHANNELS         = 3;
    localparam int ENTRY_W          = CHANNELS * SUM_W;
    localparam int QDEPTH           = 4;
    localparam int QPTR_W           = 2;
    localparam int CFG_IDX_W        = 2;

    localparam logic [SHIFT_W-1:0] MAX_BLOCK_SHIFT = 4'd10;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            start_of_frame;
    } pixel_t;

    typedef struct packed {
        logic [COL_W-1:0] block_row;
        logic [COL_W-1:0] block_col;
        logic [CH_W-1:0]  avg_red;
        logic [CH_W-1:0]  avg_green;
        logic [CH_W-1:0]  avg_blue;
        logic             frame_done;
    } result_t;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
    } cfg_t;

    // Classified pixel handed from front to back
    typedef struct packed {
        logic [COL_W-1:0] blk_col;
        logic [COL_W-1:0] blk_row;
        logic             first;
        logic             emit;
        logic             frame_done;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } work_t;

    typedef struct packed {
        logic  push;
        work_t item;
    } push_t;

    typedef struct packed {
        logic              valid;
        logic [QPTR_W:0]   level;
        work_t             item;
    } qhead_t;

endpackage

/* sv/block_mosaic_average.sv */
// Top level of the block mosaic averager: config registers, front, queue, back.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------
//  pix     | in  | pix_valid / pix_ready   | pixel_t: r, g, b, start_of_frame
//  avg     | out | avg_valid / avg_ready   | result_t: block row/col, averages
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_index (2b), cfg_data (12b)
//
// One pixel per clock sustained while results are taken; a pixel passes the queue,
// then the sum RAM read register, then add and scale into the result register.
// The single-port-per-direction column-sum RAM is read once and written once
// per pixel; a write-to-read bypass covers the back-to-back same-column case.
// Reset clears position counters, queue and pipeline valid bits; the sum RAM
// is not cleared (a block's top-left pixel overwrites its entry).
// A stalled result holds the back end; the 4-entry queue then fills and
// pix_ready drops. cfg_ready is always high.
module block_mosaic_average
    import bma_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  pixel_t               pix,
    output logic                 avg_valid,
    input  logic                 avg_ready,
    output result_t              avg,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [SHIFT_W-1:0] block_shift_reg;
    logic [CFG_W-1:0]   frame_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    cfg_t               cfg;
    push_t              wr;
    qhead_t             head;
    logic               q_full;
    logic               pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_shift_reg  <= SHIFT_W'(1);
            frame_width_reg  <= CFG_W'(640);
            frame_height_reg <= CFG_W'(480);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BLOCK_SHIFT:  block_shift_reg  <= cfg_data[SHIFT_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp sizes to 1..max and the shift to its maximum
    always_comb
    begin
        cfg.shift = (block_shift_reg > MAX_BLOCK_SHIFT) ? MAX_BLOCK_SHIFT : block_shift_reg;
        if (frame_width_reg == '0)
            cfg.width = CFG_W'(1);
        else if (frame_width_reg > CFG_W'(MAX_FRAME_WIDTH))
            cfg.width = CFG_W'(MAX_FRAME_WIDTH);
        else
            cfg.width = frame_width_reg;
        if (frame_height_reg == '0)
            cfg.height = CFG_W'(1);
        else if (frame_height_reg > CFG_W'(MAX_FRAME_HEIGHT))
            cfg.height = CFG_W'(MAX_FRAME_HEIGHT);
        else
            cfg.height = frame_height_reg;
    end

    bma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .q_full    (q_full),
        .wr        (wr)
    );

    bma_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    bma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .pop       (pop),
        .avg_valid (avg_valid),
        .avg_ready (avg_ready),
        .avg       (avg)
    );

    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        head.level <= (QPTR_W+1)'(QDEPTH))
        else $error("queue level beyond depth");

    // back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

    // a push lands in the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr.push && !pop) |=> head.level == $past(head.level) + (QPTR_W+1)'(1))
        else $error("queue level did not track push");

    // the last block of a frame sits at the bottom-right of the block grid
    assert property (@(posedge clk) disable iff (!rst_n)
        (avg_valid && avg.frame_done) |->
            (avg.block_col == COL_W'((cfg.width - CFG_W'(1)) >> cfg.shift)) &&
            (avg.block_row == COL_W'((cfg.height - CFG_W'(1)) >> cfg.shift)))
        else $error("frame end block off the grid corner");

endmodule

/* sv/bma_front.sv */
// Front end: tracks pixel position and classifies each accepted pixel.
module bma_front
    import bma_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   pix_valid,
    output logic   pix_ready,
    input  pixel_t pix,
    input  logic   q_full,
    output push_t  wr
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [COL_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_start, row_start, col_eff, row_eff, mask;
    logic [CFG_W-1:0] col_inc, row_inc, w_last, h_last;
    logic             accept, last_col, last_row, at_w_last, at_h_last;

    assign pix_ready = !q_full;
    assign accept    = pix_valid && pix_ready;

    always_comb
    begin
        col_start = pix.start_of_frame ? '0 : col_reg;
        row_start = pix.start_of_frame ? '0 : row_reg;
        // counters left outside a shrunken frame wrap to zero
        col_eff   = ({1'b0, col_start} >= cfg.width)  ? '0 : col_start;
        row_eff   = ({1'b0, row_start} >= cfg.height) ? '0 : row_start;
        mask      = (COL_W'(1) << cfg.shift) - COL_W'(1);
        w_last    = cfg.width - CFG_W'(1);
        h_last    = cfg.height - CFG_W'(1);
        at_w_last = ({1'b0, col_eff} == w_last);
        at_h_last = ({1'b0, row_eff} == h_last);
        last_col  = ((col_eff & mask) == mask) || at_w_last;
        last_row  = ((row_eff & mask) == mask) || at_h_last;

        wr.push            = accept;
        wr.item.blk_col    = col_eff >> cfg.shift;
        wr.item.blk_row    = row_eff >> cfg.shift;
        wr.item.first      = ((row_eff & mask) == '0) && ((col_eff & mask) == '0);
        wr.item.emit       = last_col && last_row;
        wr.item.frame_done = at_w_last && at_h_last;
        wr.item.red        = pix.red_in;
        wr.item.green      = pix.green_in;
        wr.item.blue       = pix.blue_in;

        col_inc  = {1'b0, col_eff} + CFG_W'(1);
        row_inc  = {1'b0, row_eff} + CFG_W'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= cfg.width)
            begin
                col_next = '0;
                row_next = (row_inc >= cfg.height) ? '0 : row_inc[COL_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* sv/bma_queue.sv */
// Short FIFO of classified pixels between front and back.
module bma_queue
    import bma_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  wr,
    output logic   full,
    input  logic   pop,
    output qhead_t head
);

    work_t             entries_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   level_reg, level_next;

    assign full       = (level_reg == (QPTR_W+1)'(QDEPTH));
    assign head.valid = (level_reg != '0);
    assign head.level = level_reg;
    assign head.item  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr.push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop     ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg;
        if (wr.push && !pop)
            level_next = level_reg + (QPTR_W+1)'(1);
        else if (pop && !wr.push)
            level_next = level_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            entries_reg[wr_ptr_reg] <= wr.item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

/* sv/bma_back.sv */
// Back end: column-sum read-modify-write, averaging and result register.
module bma_back
    import bma_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  qhead_t  head,
    output logic    pop,
    output logic    avg_valid,
    input  logic    avg_ready,
    output result_t avg
);

    logic [ENTRY_W-1:0] mem [MAX_FRAME_WIDTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [ENTRY_W-1:0] fwd_data_reg;
    logic [COL_W-1:0]   fwd_addr_reg;
    logic               fwd_valid_reg;
    work_t              s1_reg;
    logic               s1_valid_reg, s1_valid_next;
    result_t            avg_reg, avg_next;
    logic               avg_valid_reg, avg_valid_next;
    logic               s1_adv;
    logic [ENTRY_W-1:0] base, sums;
    logic [SUM_W-1:0]   sum_r, sum_g, sum_b;
    logic [AMT_W-1:0]   amt;

    function automatic logic [CH_W-1:0] scale(input logic [SUM_W-1:0] s,
                                              input logic [AMT_W-1:0] a);
        logic [SUM_W-1:0] q;
        q = s >> a;
        scale = (q[SUM_W-1:CH_W] != '0) ? '1 : q[CH_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] accum(input logic [SUM_W-1:0] s,
                                               input logic [CH_W-1:0] p,
                                               input logic first);
        accum = first ? SUM_W'(p) : s + SUM_W'(p);
    endfunction

    assign s1_adv    = s1_valid_reg && (!s1_reg.emit || !avg_valid_reg || avg_ready);
    assign pop       = head.valid && (!s1_valid_reg || s1_adv);
    assign avg_valid = avg_valid_reg;
    assign avg       = avg_reg;

    always_comb
    begin
        // last write may not have landed before this entry was read
        base  = (fwd_valid_reg && fwd_addr_reg == s1_reg.blk_col) ? fwd_data_reg
                                                                  : rd_data_reg;
        sum_r = accum(base[3*SUM_W-1:2*SUM_W], s1_reg.red,   s1_reg.first);
        sum_g = accum(base[2*SUM_W-1:SUM_W],   s1_reg.green, s1_reg.first);
        sum_b = accum(base[SUM_W-1:0],         s1_reg.blue,  s1_reg.first);
        sums  = {sum_r, sum_g, sum_b};
        amt   = {cfg.shift, 1'b0};

        avg_next            = avg_reg;
        avg_next.block_row  = s1_reg.blk_row;
        avg_next.block_col  = s1_reg.blk_col;
        avg_next.avg_red    = scale(sum_r, amt);
        avg_next.avg_green  = scale(sum_g, amt);
        avg_next.avg_blue   = scale(sum_b, amt);
        avg_next.frame_done = s1_reg.frame_done;

        s1_valid_next = pop || (s1_valid_reg && !s1_adv);

        if (s1_adv && s1_reg.emit)
            avg_valid_next = 1'b1;
        else if (avg_ready)
            avg_valid_next = 1'b0;
        else
            avg_valid_next = avg_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= mem[head.item.blk_col];
            s1_reg      <= head.item;
        end
        if (s1_adv)
        begin
            mem[s1_reg.blk_col] <= sums;
            fwd_data_reg        <= sums;
            fwd_addr_reg        <= s1_reg.blk_col;
        end
        if (s1_adv && s1_reg.emit)
            avg_reg <= avg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            avg_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            avg_valid_reg <= avg_valid_next;
            if (s1_adv)
                fwd_valid_reg <= 1'b1;
        end
    end

endmodule
